>>> hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // block size is a power of two so block index and byte offset are a shift apart
   localparam int BLOCK_BYTES = 32;
   localparam int BLOCK_SHIFT = 5;

   // used-map word geometry
   localparam int MAP_BITS  = 64;
   localparam int MAP_SHIFT = 6;

   // configuration port
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam bit REG_POOL_BASE = 1'b0;

   // commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic        command;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] block_address;
   } rsp_type;

   // lowest free bit of one used-map word
   typedef struct packed {
      logic                 found;
      logic [MAP_SHIFT-1:0] bit_idx;
      logic [MAP_BITS-1:0]  mask;
   } zfind_type;

endpackage

>>> hdl/bba_map_ram.sv
// ----------------------------------------------------------------------------
// bba_map_ram
// Used-map memory, one word per row, with a valid bit per row so that reset
// clears the whole map at once. A row never written reads as all free.
// ----------------------------------------------------------------------------
module bba_map_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [bba_pkg::MAP_BITS-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [bba_pkg::MAP_BITS-1:0] wr_data
);

   logic [bba_pkg::MAP_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]             row_vld_ff;
   logic [DEPTH-1:0]             row_vld_in;
   logic [bba_pkg::MAP_BITS-1:0] rd_word_ff;
   logic                         rd_vld_ff;

   always_comb begin
      row_vld_in = row_vld_ff;
      if (wr_en) begin
         row_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else begin
         row_vld_ff <= row_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_word_ff <= mem[rd_addr];
      rd_vld_ff  <= row_vld_ff[rd_addr];
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

endmodule

>>> hdl/bba_zero_find.sv
// ----------------------------------------------------------------------------
// bba_zero_find
// Finds the lowest clear bit of one used-map word: one-hot mask and index.
// ----------------------------------------------------------------------------
module bba_zero_find (
   input  logic [bba_pkg::MAP_BITS-1:0] word,
   output bba_pkg::zfind_type           result
);

   logic [bba_pkg::MAP_BITS-1:0]  mask;
   logic [bba_pkg::MAP_SHIFT-1:0] bit_idx;

   // the carry of word + 1 stops at the first zero
   assign mask = ~word & (word + bba_pkg::MAP_BITS'(1));

   always_comb begin
      bit_idx = '0;
      for (int i = 0; i < bba_pkg::MAP_BITS; i++) begin
         if (mask[i]) begin
            bit_idx = bit_idx | bba_pkg::MAP_SHIFT'(i);
         end
      end
   end

   assign result.found   = |mask;
   assign result.bit_idx = bit_idx;
   assign result.mask    = mask;

endmodule

>>> hdl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Fixed-size block allocator over a used-map with one bit per block.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall   bba_pkg::req_type
//  rsp      out        rsp_valid / rsp_stall   bba_pkg::rsp_type
//  csr      in/out     psel/penable/pready     pool_base at byte address 0
//
//  allocate: one used-map word checked per cycle by the zero finder, the next word
//  read ahead while the previous one is checked; the result is full when no free
//  bit lies below the last block.
//  free: range check and read, write back, result; no write back when the address
//  lies outside the pool.
//  one item in work at a time; the next item is taken while a result still waits.
//  reset clears the used-map at once through per-row valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
   parameter int BLOCKS_PER_PAGE = 1024,
   parameter int NUM_PAGES       = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bba_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bba_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int TOTAL_BLOCKS = NUM_PAGES * BLOCKS_PER_PAGE;
   localparam int POOL_BYTES   = TOTAL_BLOCKS * bba_pkg::BLOCK_BYTES;
   localparam int MAP_WORDS    = (TOTAL_BLOCKS + bba_pkg::MAP_BITS - 1) / bba_pkg::MAP_BITS;
   localparam int WORD_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W        = WORD_W + bba_pkg::MAP_SHIFT;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_FREE_RD = 3'd2;
   localparam logic [2:0] S_FREE_WR = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic                          cmd_ff, cmd_in;
   logic [31:0]                   addr_ff, addr_in;
   logic [WORD_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [WORD_W-1:0]             chk_ptr_ff, chk_ptr_in;
   logic                          issued_ff, issued_in;
   logic [WORD_W-1:0]             word_ff, word_in;
   logic [bba_pkg::MAP_SHIFT-1:0] bit_ff, bit_in;
   logic [1:0]                    res_status_ff, res_status_in;
   logic [IDX_W-1:0]              res_idx_ff, res_idx_in;
   logic [31:0]                   pool_base_ff, pool_base_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bba_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                          req_accept;
   logic                          csr_write;
   logic [31:0]                   offset;
   logic                          in_pool;
   logic [WORD_W-1:0]             free_word;
   logic [IDX_W-1:0]              scan_idx;
   logic [WORD_W-1:0]             rd_addr;
   logic [bba_pkg::MAP_BITS-1:0]  rd_data;
   logic                          wr_en;
   logic [WORD_W-1:0]             wr_addr;
   logic [bba_pkg::MAP_BITS-1:0]  wr_data;
   bba_pkg::zfind_type            zf;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == bba_pkg::REG_POOL_BASE) ? pool_base_ff : '0;

   always_comb begin
      pool_base_in = pool_base_ff;
      if (csr_write && csr_paddr[2] == bba_pkg::REG_POOL_BASE) begin
         pool_base_in = csr_pwdata;
      end
   end

   // free address decode
   assign offset    = addr_ff - pool_base_ff;
   assign in_pool   = offset < 32'(POOL_BYTES);
   assign free_word = offset[bba_pkg::BLOCK_SHIFT + bba_pkg::MAP_SHIFT +: WORD_W];

   assign scan_idx = {chk_ptr_ff, zf.bit_idx};
   assign rd_addr  = (state_ff == S_FREE_RD) ? free_word : rd_ptr_ff;

   bba_map_ram #(
      .DEPTH  (MAP_WORDS),
      .ADDR_W (WORD_W)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bba_zero_find u_zfind (
      .word   (rd_data),
      .result (zf)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      rd_ptr_in     = rd_ptr_ff;
      chk_ptr_in    = chk_ptr_ff;
      issued_in     = issued_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_ptr_ff;
      wr_data       = rd_data | zf.mask;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_data.command;
               addr_in   = req_data.address;
               rd_ptr_in = '0;
               issued_in = 1'b0;
               state_in  = (req_data.command == bba_pkg::CMD_FREE) ? S_FREE_RD : S_SCAN;
            end
         end
         S_SCAN: begin
            // read one word ahead while the previous one is checked
            issued_in  = 1'b1;
            chk_ptr_in = rd_ptr_ff;
            if (rd_ptr_ff != WORD_W'(MAP_WORDS - 1)) begin
               rd_ptr_in = rd_ptr_ff + WORD_W'(1);
            end
            if (issued_ff) begin
               if (zf.found) begin
                  // a free bit past the last block means the pool is full
                  if (32'(scan_idx) < 32'(TOTAL_BLOCKS)) begin
                     wr_en         = 1'b1;
                     res_status_in = bba_pkg::ST_OK;
                     res_idx_in    = scan_idx;
                  end else begin
                     res_status_in = bba_pkg::ST_FULL;
                  end
                  state_in = S_DONE;
               end else if (chk_ptr_ff == WORD_W'(MAP_WORDS - 1)) begin
                  res_status_in = bba_pkg::ST_FULL;
                  state_in      = S_DONE;
               end
            end
         end
         S_FREE_RD: begin
            word_in = free_word;
            bit_in  = offset[bba_pkg::BLOCK_SHIFT +: bba_pkg::MAP_SHIFT];
            if (in_pool) begin
               state_in = S_FREE_WR;
            end else begin
               res_status_in = bba_pkg::ST_RANGE;
               state_in      = S_DONE;
            end
         end
         S_FREE_WR: begin
            wr_en         = 1'b1;
            wr_addr       = word_ff;
            wr_data       = rd_data & ~(bba_pkg::MAP_BITS'(1) << bit_ff);
            res_status_in = bba_pkg::ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = res_status_ff;
               if (cmd_ff == bba_pkg::CMD_ALLOC && res_status_ff == bba_pkg::ST_OK) begin
                  rsp_data_in.block_address =
                     pool_base_ff + (32'(res_idx_ff) << bba_pkg::BLOCK_SHIFT);
               end else begin
                  rsp_data_in.block_address = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pool_base_ff <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         pool_base_ff <= pool_base_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      rd_ptr_ff     <= rd_ptr_in;
      chk_ptr_ff    <= chk_ptr_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

>>> hdl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bba_pkg::rsp_type rsp_data
);

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a failed item carries a zero block address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != bba_pkg::ST_OK |-> rsp_data.block_address == '0)
      else $error("failed item carries a block address");

   // the block is busy right after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken while previous one in work");

   // reset leaves the block idle with no result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap block allocator. A short table of
// allocate and free items is run first. Random segments then fill part of the
// pool, drain it and mix in-pool frees with out-of-range noise, under several
// pool bases. Most table rows carry their own expected result; every other
// result is checked against a behavioral model of the used-map kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

   localparam int TB_BLOCKS_PER_PAGE = 1024;
   localparam int TB_NUM_PAGES       = 4;
   localparam int TOTAL_BLOCKS       = TB_BLOCKS_PER_PAGE * TB_NUM_PAGES;
   localparam logic [31:0] POOL_BYTES = TOTAL_BLOCKS * bba_pkg::BLOCK_BYTES;

   localparam logic [bba_pkg::CSR_ADDR_W-1:0] CSR_POOL_BASE =
      bba_pkg::CSR_ADDR_W'(4 * bba_pkg::REG_POOL_BASE);
   localparam logic [bba_pkg::CSR_ADDR_W-1:0] CSR_UNUSED = bba_pkg::CSR_ADDR_W'(4);

   localparam int PHASE_ITEMS = 300;
   localparam int LONG_HOLD   = 300;

   typedef enum int {SEG_MIXED, SEG_FILL, SEG_DRAIN, SEG_NOISE} segment_kind_type;

   typedef struct packed {
      bba_pkg::req_type item;
      logic             typed;
      bba_pkg::rsp_type want;
   } dir_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   bba_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   bba_pkg::rsp_type               rsp_data;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [bba_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bba_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bba_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // model of the block
   logic [TOTAL_BLOCKS-1:0] block_used;
   logic [31:0]             base_shadow;
   bba_pkg::rsp_type        awaited_rsp[$];

   int errors;
   int send_gap_max;
   int recv_wait_max;
   bit long_hold_req;

   dir_row_type directed_rows [19] = '{
      '{'{bba_pkg::CMD_ALLOC, 32'h0000_0000},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0000}},
      '{'{bba_pkg::CMD_ALLOC, 32'hFFFF_FFFF},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0020}},
      '{'{bba_pkg::CMD_ALLOC, 32'h0000_0000},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0040}},
      '{'{bba_pkg::CMD_FREE,  32'h0000_003F},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0000}},
      '{'{bba_pkg::CMD_FREE,  32'h0000_0020},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0000}},
      '{'{bba_pkg::CMD_ALLOC, 32'h0000_0000},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0020}},
      '{'{bba_pkg::CMD_FREE,  32'h0000_0000},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0000}},
      '{'{bba_pkg::CMD_FREE,  32'hFFFF_FFFF},  1'b1, '{bba_pkg::ST_RANGE, 32'h0000_0000}},
      '{'{bba_pkg::CMD_FREE,  POOL_BYTES - 1}, 1'b1, '{bba_pkg::ST_OK,    32'h0000_0000}},
      '{'{bba_pkg::CMD_FREE,  POOL_BYTES},     1'b1, '{bba_pkg::ST_RANGE, 32'h0000_0000}},
      '{'{bba_pkg::CMD_FREE,  32'h8000_0000},  1'b1, '{bba_pkg::ST_RANGE, 32'h0000_0000}},
      '{'{bba_pkg::CMD_ALLOC, 32'h0000_0000},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0000}},
      '{'{bba_pkg::CMD_ALLOC, 32'h0000_0000},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0060}},
      '{'{bba_pkg::CMD_FREE,  32'h7FFF_FFFF},  1'b1, '{bba_pkg::ST_RANGE, 32'h0000_0000}},
      '{'{bba_pkg::CMD_FREE,  32'h0000_0041},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0000}},
      '{'{bba_pkg::CMD_ALLOC, 32'h0000_0000},  1'b1, '{bba_pkg::ST_OK,    32'h0000_0040}},
      '{'{bba_pkg::CMD_FREE,  32'h5555_5555},  1'b0, '{bba_pkg::ST_OK,    32'h0000_0000}},
      '{'{bba_pkg::CMD_FREE,  32'h0000_0AAA},  1'b0, '{bba_pkg::ST_OK,    32'h0000_0000}},
      '{'{bba_pkg::CMD_ALLOC, 32'hAAAA_AAAA},  1'b0, '{bba_pkg::ST_OK,    32'h0000_0000}}
   };

   bitmap_block_allocator #(
      .BLOCKS_PER_PAGE(TB_BLOCKS_PER_PAGE),
      .NUM_PAGES      (TB_NUM_PAGES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   // allocate takes the lowest free block, free clears the block holding the byte
   function automatic bba_pkg::rsp_type predict_response(input bba_pkg::req_type it);
      bba_pkg::rsp_type r;
      logic [31:0]      offset;
      logic [31:0]      step;
      int               idx;
      r.status = bba_pkg::ST_OK;
      r.block_address = '0;
      idx = -1;
      if (it.command == bba_pkg::CMD_ALLOC) begin
         for (int i = 0; i < TOTAL_BLOCKS; i++) begin
            if (!block_used[i]) begin
               idx = i;
               break;
            end
         end
         if (idx < 0) begin
            r.status = bba_pkg::ST_FULL;
         end else begin
            block_used[idx] = 1'b1;
            step = idx * bba_pkg::BLOCK_BYTES;
            r.block_address = base_shadow + step;
         end
      end else begin
         offset = it.address - base_shadow;
         if (offset < POOL_BYTES) begin
            block_used[offset / bba_pkg::BLOCK_BYTES] = 1'b0;
         end else begin
            r.status = bba_pkg::ST_RANGE;
         end
      end
      return r;
   endfunction

   function automatic int pick_block(input bit want_used);
      int n;
      int k;
      n = 0;
      for (int i = 0; i < TOTAL_BLOCKS; i++) begin
         if (block_used[i] == want_used) n++;
      end
      if (n == 0) return -1;
      k = $urandom_range(n - 1, 0);
      for (int i = 0; i < TOTAL_BLOCKS; i++) begin
         if (block_used[i] == want_used) begin
            if (k == 0) return i;
            k--;
         end
      end
      return -1;
   endfunction

   function automatic logic [31:0] byte_in_block(input int idx);
      logic [31:0] step;
      step = idx * bba_pkg::BLOCK_BYTES + $urandom_range(bba_pkg::BLOCK_BYTES - 1, 0);
      return base_shadow + step;
   endfunction

   function automatic bba_pkg::req_type make_request(input segment_kind_type kind);
      bba_pkg::req_type it;
      int               pick;
      int               idx;
      it.command = bba_pkg::CMD_ALLOC;
      it.address = $urandom;
      pick = $urandom_range(9, 0);
      case (kind)
         SEG_FILL: begin
            it.command = bba_pkg::CMD_ALLOC;
         end
         SEG_DRAIN, SEG_MIXED: begin
            if (kind == SEG_MIXED && pick < 6) begin
               it.command = bba_pkg::CMD_ALLOC;
            end else begin
               it.command = bba_pkg::CMD_FREE;
               idx = pick_block(1'b1);
               // a random byte of the pool, free or not, when nothing is in use or pick is 9
               if (idx >= 0 && pick < 9) it.address = byte_in_block(idx);
               else it.address = base_shadow + $urandom_range(POOL_BYTES - 1, 0);
            end
         end
         default: begin
            it.command = bba_pkg::CMD_FREE;
            case (pick % 6)
               0: it.command = $urandom_range(1, 0) ? bba_pkg::CMD_FREE : bba_pkg::CMD_ALLOC;
               1: it.address = base_shadow - 1;
               2: it.address = base_shadow + POOL_BYTES;
               3: it.address = base_shadow + POOL_BYTES - 1;
               4: it.address = base_shadow;
               default: it.command = bba_pkg::CMD_ALLOC;
            endcase
         end
      endcase
      return it;
   endfunction

   task automatic send_request(input bba_pkg::req_type it, input logic typed,
                               input bba_pkg::rsp_type want);
      int gap;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      if (typed) begin
         void'(predict_response(it));
         awaited_rsp.push_back(want);
      end else begin
         awaited_rsp.push_back(predict_response(it));
      end
   endtask

   // drop valid before the block goes idle again
   task automatic stop_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic csr_access(input logic wr, input logic [bba_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [bba_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [bba_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // only while idle: every awaited result is in
   task automatic write_register(input logic [bba_pkg::CSR_ADDR_W-1:0] addr,
                                 input logic [bba_pkg::CSR_DATA_W-1:0] value);
      logic [bba_pkg::CSR_DATA_W-1:0] rd;
      stop_requests();
      wait (awaited_rsp.size() == 0);
      repeat (4) @(posedge clock);
      csr_access(1'b1, addr, value, rd);
      if (addr == CSR_POOL_BASE) base_shadow = value;
      csr_access(1'b0, CSR_POOL_BASE, '0, rd);
      if (rd !== base_shadow) begin
         report_mismatch($sformatf("pool_base reads %h, expected %h", rd, base_shadow));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      bba_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_data));
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               report_mismatch($sformatf("status %h, expected %h",
                                         rsp_data.status, want.status));
            end
            if (rsp_data.block_address !== want.block_address) begin
               report_mismatch($sformatf("block_address %h, expected %h",
                                         rsp_data.block_address, want.block_address));
            end
         end
      end
   end

   // result receiver: stall for a drawn number of cycles, then take one item
   initial begin
      int n;
      wait (!reset);
      forever begin
         if (long_hold_req) begin
            n = LONG_HOLD;
            long_hold_req = 1'b0;
         end else begin
            n = $urandom_range(recv_wait_max, 0);
         end
         for (int i = 0; i < n; i++) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL bitmap_block_allocator");
      $finish;
   end

   initial begin
      logic [31:0]      phase_base [5];
      segment_kind_type kind;
      int               seg_len;
      int               sent;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      errors        = 0;
      send_gap_max  = 14;
      recv_wait_max = 14;
      long_hold_req = 1'b0;
      block_used    = '0;
      base_shadow   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      // the first two bases wrap past the top of the address space
      phase_base[0] = 32'hFFFF_FFFF;
      phase_base[1] = 32'hFFFF_F400;
      phase_base[2] = $urandom;
      phase_base[3] = 32'h0000_0000;
      phase_base[4] = $urandom;

      write_register(CSR_UNUSED, $urandom);
      for (int p = 0; p < 5; p++) begin
         write_register(CSR_POOL_BASE, phase_base[p]);
         if (p == 1) long_hold_req = 1'b1;
         sent = 0;
         kind = SEG_FILL;
         while (sent < PHASE_ITEMS) begin
            if (kind == SEG_FILL) seg_len = $urandom_range(80, 20);
            else seg_len = $urandom_range(40, 10);
            send_gap_max  = ($urandom_range(3, 0) == 0) ? 0 : 14;
            recv_wait_max = ($urandom_range(3, 0) == 0) ? 0 : 14;
            for (int i = 0; i < seg_len && sent < PHASE_ITEMS; i++) begin
               send_request(make_request(kind), 1'b0, '0);
               sent++;
            end
            case ($urandom_range(9, 0))
               0, 1:    kind = SEG_FILL;
               2, 3:    kind = SEG_DRAIN;
               4:       kind = SEG_NOISE;
               default: kind = SEG_MIXED;
            endcase
         end
         // pause until the block has answered everything
         if (p == 2) begin
            stop_requests();
            wait (awaited_rsp.size() == 0);
         end
      end

      stop_requests();
      wait (awaited_rsp.size() == 0);
      repeat (80) @(posedge clock);
      if (errors == 0) begin
         $display("PASS bitmap_block_allocator");
      end else begin
         $display("FAIL bitmap_block_allocator");
      end
      $finish;
   end

endmodule
